[design/kdtu_pkg.sv]
// Package for the kd-tree tag update block: field widths, beat and geometry types,
// and the highest-set-bit helper. No dependencies.
package kdtu_pkg;

    localparam int TAG_W   = 16;
    localparam int POS_W   = 16;
    localparam int LVL_W   = 5;
    localparam int CNT_W   = 17;
    localparam int NEXT_W  = 17;
    localparam int DEPTH_W = 5;

    // Tree geometry derived from the element count at config time
    typedef struct packed {
        logic [CNT_W-1:0]   count_n;  // clamped element count, n
        logic [DEPTH_W-1:0] depth;    // floor(log2(n))
        logic [CNT_W-1:0]   on_last;  // nodes on the bottom level
    } t_geom;

    typedef struct packed {
        logic [TAG_W-1:0] node_tag;
        logic [POS_W-1:0] position;
        logic [LVL_W-1:0] level_now;
    } t_in_beat;

    typedef struct packed {
        logic [NEXT_W-1:0] next_tag;
        logic              settled;
    } t_out_beat;

    // Index of the highest set bit; 0 for a zero word
    function automatic logic [DEPTH_W-1:0] f_msb_idx(input logic [CNT_W-1:0] v);
        logic [DEPTH_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (v[b]) begin
                idx = DEPTH_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

[design/kdtu_in_if.sv]
// Input channel of the kd-tree tag update block: valid/ready plus element fields.
// Depends on kdtu_pkg.
interface kdtu_in_if
    import kdtu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] node_tag;
    logic [POS_W-1:0] position;
    logic [LVL_W-1:0] level_now;

    modport source (output valid, node_tag, position, level_now, input ready);
    modport sink   (input valid, node_tag, position, level_now, output ready);
endinterface

[design/kdtu_out_if.sv]
// Output channel of the kd-tree tag update block: valid/ready plus result fields.
// Depends on kdtu_pkg.
interface kdtu_out_if
    import kdtu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NEXT_W-1:0] next_tag;
    logic              settled;

    modport source (output valid, next_tag, settled, input ready);
    modport sink   (input valid, next_tag, settled, output ready);
endinterface

[design/kd_tree_tag_update.sv]
// Top level of the kd-tree tag update block: count register and pivot pipeline.
// Depends on kdtu_pkg, kdtu_in_if, kdtu_out_if, kdtu_cfg and kdtu_pipe.
//
// Usage
//   Input channel i_in carries one element per beat: node_tag, position in the
//   tag-sorted array and the level being split. Output channel o_out returns one
//   beat per input beat, in order: next_tag (same node, left or right child,
//   saturated at 131071) and settled.
//   i_cfg_we / i_cfg_data write the element count; the value is clamped to
//   1..MAX_NODES and depth and bottom-level occupancy are derived at the write,
//   so a beat may follow in the very next cycle. Write only while idle.
// Timing
//   Four register stages lie between input beat and output valid: decode, shift,
//   segment start / subtree size, compare.
//   Throughput is one beat per cycle while the receiver holds ready high.
// Reset and stalls
//   Synchronous active-low reset empties the pipeline and sets the count to 1.
//   When the receiver holds ready low the result stays in the output register;
//   upstream stages keep filling bubbles, and input ready drops only once every
//   stage holds a beat. Nothing is dropped or repeated.
module kd_tree_tag_update
    import kdtu_pkg::*;
#(
    parameter int MAX_NODES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    kdtu_in_if.sink          i_in,
    kdtu_out_if.source       o_out
);

    t_geom     geom;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    logic      pipe_ready;
    logic      pipe_valid;

    kdtu_cfg #(
        .MAX_NODES (MAX_NODES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_data  (i_cfg_data),
        .o_geom  (geom)
    );

    assign in_beat.node_tag  = i_in.node_tag;
    assign in_beat.position  = i_in.position;
    assign in_beat.level_now = i_in.level_now;

    kdtu_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (i_in.valid),
        .o_ready (pipe_ready),
        .i_beat  (in_beat),
        .o_valid (pipe_valid),
        .i_ready (o_out.ready),
        .o_beat  (out_beat)
    );

    assign i_in.ready     = pipe_ready;
    assign o_out.valid    = pipe_valid;
    assign o_out.next_tag = out_beat.next_tag;
    assign o_out.settled  = out_beat.settled;

endmodule

[design/kdtu_cfg.sv]
// Element count register: clamps the written count and derives tree depth and
// bottom-level occupancy. Depends on kdtu_pkg.
module kdtu_cfg
    import kdtu_pkg::*;
#(
    parameter int MAX_NODES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [CNT_W-1:0] i_data,
    output t_geom            o_geom
);

    t_geom              r_geom;
    t_geom              n_geom;
    logic [31:0]        wide;
    logic [CNT_W-1:0]   cnt;
    logic [DEPTH_W-1:0] dep;

    always_comb begin
        wide = {{(32-CNT_W){1'b0}}, i_data};
        if (i_data == '0) begin
            cnt = CNT_W'(1);
        end else if (wide > 32'(MAX_NODES)) begin
            cnt = CNT_W'(MAX_NODES);
        end else begin
            cnt = i_data;
        end
        dep             = f_msb_idx(cnt);
        n_geom.count_n  = cnt;
        n_geom.depth    = dep;
        n_geom.on_last  = cnt - (CNT_W'(1) << dep) + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.count_n <= CNT_W'(1);
            r_geom.depth   <= '0;
            r_geom.on_last <= CNT_W'(1);
        end else if (i_we) begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule

[design/kdtu_pipe.sv]
// Four-stage pivot pipeline: decode, shifts, segment start / subtree size, compare.
// Per-stage valid bits with a ready chain. Depends on kdtu_pkg.
module kdtu_pipe
    import kdtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geom     i_geom,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  pos;
        logic              above;
        logic              lvl0;
        logic              span_pos;
        logic [TAG_W-1:0]  fol;
        logic [TAG_W-1:0]  ls;
        logic [3:0]        span1;
        logic [CNT_W-1:0]  c;
        logic              c_ge_n;
        logic              leaf;
        logic [3:0]        span2;
    } t_s1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  pos;
        logic              above;
        logic              lvl0;
        logic              span_pos;
        logic [TAG_W-1:0]  fol;
        logic [TAG_W-1:0]  ls;
        logic [30:0]       sh;
        logic              c_ge_n;
        logic              leaf;
        logic [17:0]       fl;
        logic [15:0]       cap;
    } t_s2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  pos;
        logic              above;
        logic [31:0]       start;
        logic [CNT_W-1:0]  sub;
    } t_s3;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_s3       r_s3, n_s3;
    t_out_beat r_s4, n_s4;

    // Stall chain: a stage moves when empty or when the one after it moves
    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // Stage 1: level decode, child depth, span widths
    logic [CNT_W-1:0]   fol17;
    logic [CNT_W-1:0]   tp1;
    logic [DEPTH_W-1:0] l2;
    always_comb begin
        fol17          = (CNT_W'(1) << i_beat.level_now) - CNT_W'(1);
        tp1            = {1'b0, i_beat.node_tag} + CNT_W'(1);
        l2             = f_msb_idx(tp1) + DEPTH_W'(1);
        n_s1.tag       = i_beat.node_tag;
        n_s1.pos       = i_beat.position;
        n_s1.above     = {1'b0, i_beat.node_tag} < fol17;
        n_s1.lvl0      = i_beat.level_now == '0;
        n_s1.span_pos  = i_geom.depth > i_beat.level_now;
        n_s1.fol       = fol17[TAG_W-1:0];
        n_s1.ls        = i_beat.node_tag - fol17[TAG_W-1:0];
        n_s1.span1     = 4'(i_geom.depth - i_beat.level_now);
        n_s1.c         = {i_beat.node_tag, 1'b1};
        n_s1.c_ge_n    = {i_beat.node_tag, 1'b1} >= i_geom.count_n;
        n_s1.leaf      = l2 >= i_geom.depth;
        n_s1.span2     = 4'(i_geom.depth - l2);
    end

    // Stage 2: shifts for sibling offset and the child's first leaf
    logic [17:0] cp1;
    always_comb begin
        cp1           = {1'b0, r_s1.c} + 18'd1;
        n_s2.tag      = r_s1.tag;
        n_s2.pos      = r_s1.pos;
        n_s2.above    = r_s1.above;
        n_s2.lvl0     = r_s1.lvl0;
        n_s2.span_pos = r_s1.span_pos;
        n_s2.fol      = r_s1.fol;
        n_s2.ls       = r_s1.ls;
        n_s2.sh       = {15'd0, r_s1.ls} << r_s1.span1;
        n_s2.c_ge_n   = r_s1.c_ge_n;
        n_s2.leaf     = r_s1.leaf;
        n_s2.fl       = (cp1 << r_s1.span2) - 18'd1;
        n_s2.cap      = 16'd1 << r_s1.span2;
    end

    // Stage 3: segment start and left-subtree size
    logic [30:0]      add_c;
    logic [31:0]      off;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] lowest;
    always_comb begin
        add_c = (r_s2.sh > {14'd0, i_geom.on_last}) ? {14'd0, i_geom.on_last} : r_s2.sh;
        off   = {1'b0, r_s2.sh} - {16'd0, r_s2.ls} + {1'b0, add_c};
        if (r_s2.lvl0) begin
            n_s3.start = '0;
        end else if (r_s2.span_pos) begin
            n_s3.start = {16'd0, r_s2.fol} + off;
        end else begin
            n_s3.start = {16'd0, r_s2.fol};
        end
        room   = i_geom.count_n - r_s2.fl[CNT_W-1:0];
        lowest = '0;
        if (r_s2.fl < {1'b0, i_geom.count_n}) begin
            lowest = (room > {1'b0, r_s2.cap}) ? {1'b0, r_s2.cap} : room;
        end
        if (r_s2.c_ge_n) begin
            n_s3.sub = '0;
        end else if (r_s2.leaf) begin
            n_s3.sub = CNT_W'(1);
        end else begin
            n_s3.sub = {1'b0, r_s2.cap - 16'd1} + lowest;
        end
        n_s3.tag   = r_s2.tag;
        n_s3.pos   = r_s2.pos;
        n_s3.above = r_s2.above;
    end

    // Stage 4: pivot compare and child selection
    logic [32:0]       pivot;
    logic [NEXT_W-1:0] left_c;
    logic [NEXT_W-1:0] right_c;
    always_comb begin
        pivot   = {1'b0, r_s3.start} + {16'd0, r_s3.sub};
        left_c  = {r_s3.tag, 1'b1};
        right_c = (&r_s3.tag) ? {NEXT_W{1'b1}} : ({r_s3.tag, 1'b0} + NEXT_W'(2));
        priority if (r_s3.above) begin
            n_s4.next_tag = {1'b0, r_s3.tag};
            n_s4.settled  = 1'b1;
        end else if ({17'd0, r_s3.pos} < pivot) begin
            n_s4.next_tag = left_c;
            n_s4.settled  = 1'b0;
        end else if ({17'd0, r_s3.pos} > pivot) begin
            n_s4.next_tag = right_c;
            n_s4.settled  = 1'b0;
        end else begin
            n_s4.next_tag = {1'b0, r_s3.tag};
            n_s4.settled  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_s1 <= n_s1;
        if (adv2 && r_v1)    r_s2 <= n_s2;
        if (adv3 && r_v2)    r_s3 <= n_s3;
        if (adv4 && r_v3)    r_s4 <= n_s4;
    end

    assign o_valid = r_v4;
    assign o_beat  = r_s4;

endmodule

[design/kdtu_checker.sv]
// Port-level checks for kd_tree_tag_update, attached by bind.
// Depends on kdtu_pkg and the top level's interface ports.
module kdtu_checker
    import kdtu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [NEXT_W-1:0] i_next_tag,
    input logic              i_settled
);

    // Pipeline is empty on the cycle after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> !i_out_valid)
        else $error("output valid right after reset");

    // A free output frees the whole chain
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled although output is ready");

    // With the receiver held ready after acceptance, the accepted beat shows up as output valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result late with receiver ready");

    // A child index is never the root
    a_child_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_settled) |-> (i_next_tag != '0))
        else $error("unsettled beat with root tag");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_next_tag)
            && $stable(i_settled)))
        else $error("stalled result changed");

endmodule

bind kd_tree_tag_update kdtu_checker u_kdtu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_next_tag  (o_out.next_tag),
    .i_settled   (o_out.settled)
);
